// ===== src/alc_pkg.sv =====
// ----------------------------------------------------------------------------
// alc_pkg
// shared types, widths and divisor tables for the lux conversion pipeline
// ----------------------------------------------------------------------------
package alc_pkg;

  localparam int CNT_W   = 16;
  localparam int LUX_W   = 16;
  localparam int T_W     = 20;
  localparam int RECIP_K = 25;
  localparam int RECIP_W = RECIP_K + 1;
  localparam int SHIFT_W = 4;
  localparam int CODE_W  = 3;

  localparam logic CFG_GAIN  = 1'b0;
  localparam logic CFG_INTEG = 1'b1;

  typedef enum logic [1:0] {
    REGION_LOW,
    REGION_MID,
    REGION_UPPER,
    REGION_ZERO
  } region_t;

  typedef struct packed {
    logic             valid;
    region_t          region;
    logic [CNT_W-1:0] ch0;
    logic [CNT_W-1:0] ch1;
  } cls_t;

  typedef struct packed {
    logic           valid;
    logic [T_W-1:0] x;
  } scl_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [RECIP_W-1:0] recip;
  } div_t;

  // divisor gain*halfunits split into 2^shift times an odd factor
  function automatic div_t div_of(logic [CODE_W-1:0] gain_code,
                                  logic [CODE_W-1:0] integ_code);
    logic [2:0] ga;
    logic [1:0] ha;
    logic [1:0] mg;
    logic [2:0] mh;
    logic [4:0] m;
    div_t       d;
    ga = 3'd0;
    mg = 2'd1;
    case (gain_code)
      3'd1: ga = 3'd1;
      3'd2: ga = 3'd2;
      3'd3: ga = 3'd3;
      3'd6: begin
        ga = 3'd4;
        mg = 2'd3;
      end
      3'd7: begin
        ga = 3'd5;
        mg = 2'd3;
      end
      default: ga = 3'd0;
    endcase
    ha = 2'd0;
    mh = 3'd1;
    case (integ_code)
      3'd0: ha = 2'd1;
      3'd1: ha = 2'd0;
      3'd2: ha = 2'd2;
      3'd3: ha = 2'd3;
      3'd4: mh = 3'd3;
      3'd5: mh = 3'd5;
      3'd6: begin
        ha = 2'd1;
        mh = 3'd3;
      end
      3'd7: mh = 3'd7;
      default: ha = 2'd0;
    endcase
    m       = 5'(mg) * 5'(mh);
    d.shift = SHIFT_W'(ga) + SHIFT_W'(ha);
    // ceil(2^25 / m)
    case (m)
      5'd3:    d.recip = RECIP_W'(11184811);
      5'd5:    d.recip = RECIP_W'(6710887);
      5'd7:    d.recip = RECIP_W'(4793491);
      5'd9:    d.recip = RECIP_W'(3728271);
      5'd15:   d.recip = RECIP_W'(2236963);
      5'd21:   d.recip = RECIP_W'(1597831);
      default: d.recip = RECIP_W'(33554432);
    endcase
    return d;
  endfunction

endpackage

// ===== src/ambient_light_lux_convert.sv =====
// ----------------------------------------------------------------------------
// ambient_light_lux_convert
// two-channel photodiode counts to lux, five-stage pipeline
// a request is registered in cls, then in pa/pb, scl, prod and the output register
// throughput: one request per cycle while m_tready is high; the whole
//   pipeline holds while the output register is full and not taken
// reset: rst clears all stage valid bits and both config codes to 0
// ----------------------------------------------------------------------------
module ambient_light_lux_convert #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // visible_ir_count[15:0], ir_count[31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // lux_value[15:0], saturated[16], zero[23:17]
);

  logic [alc_pkg::CODE_W-1:0] gain_code;
  logic [alc_pkg::CODE_W-1:0] integration_code;
  alc_pkg::div_t              div;
  alc_pkg::cls_t              cls;
  alc_pkg::scl_t              scl;
  logic                       en;
  logic [alc_pkg::LUX_W-1:0]  lux_value;
  logic                       saturated;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_code        <= '0;
      integration_code <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        alc_pkg::CFG_GAIN:  gain_code        <= cfg_data;
        alc_pkg::CFG_INTEG: integration_code <= cfg_data;
        default: ;
      endcase
    end
  end

  assign div      = alc_pkg::div_of(gain_code, integration_code);
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  alc_classify u_classify (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .ch0      (s_tdata[15:0]),
    .ch1      (s_tdata[31:16]),
    .cls      (cls)
  );

  alc_weight #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_weight (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .cls   (cls),
    .shift (div.shift),
    .scl   (scl)
  );

  alc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .scl       (scl),
    .recip     (div.recip),
    .out_valid (m_tvalid),
    .lux_value (lux_value),
    .saturated (saturated)
  );

  assign m_tdata = {7'd0, saturated, lux_value};

`ifndef ASSERT_OFF
  a_sat_clamps: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[16] |-> m_tdata[15:0] == 16'hFFFF)
    else $error("saturated result not clamped");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stage");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(cls) && $stable(scl))
    else $error("pipeline moved during stall");
`endif

endmodule

// ===== src/alc_classify.sv =====
// ----------------------------------------------------------------------------
// alc_classify
// ratio region of ch1/(ch0+ch1) by exact cross-multiplication, one stage
// ----------------------------------------------------------------------------
module alc_classify (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [alc_pkg::CNT_W-1:0] ch0,
  input  logic [alc_pkg::CNT_W-1:0] ch1,
  output alc_pkg::cls_t            cls
);

  logic [alc_pkg::CNT_W:0] total;
  logic [23:0]             ch1_100;
  logic [23:0]             tot_85;
  logic [23:0]             tot_64;
  logic [23:0]             tot_45;
  alc_pkg::region_t        region_next;

  assign total   = {1'b0, ch0} + {1'b0, ch1};
  assign ch1_100 = 24'(ch1) * 24'd100;
  assign tot_85  = 24'(total) * 24'd85;
  assign tot_64  = 24'(total) * 24'd64;
  assign tot_45  = 24'(total) * 24'd45;

  always_comb begin
    if (total == '0 || ch1_100 >= tot_85) begin
      region_next = alc_pkg::REGION_ZERO;
    end else if (ch1_100 < tot_45) begin
      region_next = alc_pkg::REGION_LOW;
    end else if (ch1_100 < tot_64) begin
      region_next = alc_pkg::REGION_MID;
    end else begin
      region_next = alc_pkg::REGION_UPPER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls.valid <= 1'b0;
    end else if (en) begin
      cls.valid <= in_valid;
    end
    if (en) begin
      cls.region <= region_next;
      cls.ch0    <= ch0;
      cls.ch1    <= ch1;
    end
  end

endmodule

// ===== src/alc_weight.sv =====
// ----------------------------------------------------------------------------
// alc_weight
// region coefficients times counts, then sum or difference and power-of-two
// part of the divisor, two stages
// ----------------------------------------------------------------------------
module alc_weight #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  alc_pkg::cls_t               cls,
  input  logic [alc_pkg::SHIFT_W-1:0] shift,
  output alc_pkg::scl_t               scl
);

  localparam int CW = COEF_FRAC_BITS + 3;
  localparam int PW = CW + alc_pkg::CNT_W;
  localparam int SW = PW + 1;

  localparam logic [CW-1:0] CA_LOW =
    CW'(((64'd17743 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [CW-1:0] CB_LOW =
    CW'(((64'd11059 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [CW-1:0] CA_MID =
    CW'(((64'd42785 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [CW-1:0] CB_MID =
    CW'(((64'd19548 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [CW-1:0] CA_UPPER =
    CW'(((64'd5926 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [CW-1:0] CB_UPPER =
    CW'(((64'd1185 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000);

  logic [CW-1:0]          ca;
  logic [CW-1:0]          cb;
  logic                   p_valid;
  logic                   p_diff;
  logic [PW-1:0]          pa;
  logic [PW-1:0]          pb;
  logic [SW-1:0]          s;
  logic [SW-1:0]          t_full;
  logic [alc_pkg::T_W-1:0] t;

  always_comb begin
    case (cls.region)
      alc_pkg::REGION_LOW: begin
        ca = CA_LOW;
        cb = CB_LOW;
      end
      alc_pkg::REGION_MID: begin
        ca = CA_MID;
        cb = CB_MID;
      end
      alc_pkg::REGION_UPPER: begin
        ca = CA_UPPER;
        cb = CB_UPPER;
      end
      default: begin
        ca = '0;
        cb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= cls.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa     <= PW'(ca) * PW'(cls.ch0);
      pb     <= PW'(cb) * PW'(cls.ch1);
      p_diff <= (cls.region == alc_pkg::REGION_MID);
    end
  end

  always_comb begin
    if (p_diff) begin
      s = (pa > pb) ? SW'(pa - pb) : '0;
    end else begin
      s = {1'b0, pa} + {1'b0, pb};
    end
    // floor(2*s / 2^frac)
    t_full = s >> (COEF_FRAC_BITS - 1);
    t      = t_full[alc_pkg::T_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scl.valid <= 1'b0;
    end else if (en) begin
      scl.valid <= p_valid;
    end
    if (en) begin
      scl.x <= t >> shift;
    end
  end

endmodule

// ===== src/alc_scale.sv =====
// ----------------------------------------------------------------------------
// alc_scale
// odd part of the divisor by reciprocal multiply, then saturation, two stages
// ----------------------------------------------------------------------------
module alc_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  alc_pkg::scl_t               scl,
  input  logic [alc_pkg::RECIP_W-1:0] recip,
  output logic                        out_valid,
  output logic [alc_pkg::LUX_W-1:0]   lux_value,
  output logic                        saturated
);

  localparam int MW = alc_pkg::T_W + alc_pkg::RECIP_W;
  localparam int QW = MW - alc_pkg::RECIP_K;

  logic          m_valid;
  logic [MW-1:0] prod;
  logic [QW-1:0] q;
  logic          over;

  assign q    = prod[MW-1:alc_pkg::RECIP_K];
  assign over = |q[QW-1:alc_pkg::LUX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      m_valid   <= scl.valid;
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod      <= MW'(scl.x) * MW'(recip);
      lux_value <= over ? '1 : q[alc_pkg::LUX_W-1:0];
      saturated <= over;
    end
  end

endmodule
